/* hw/rtl/rounded_rect_scanline_span_unit_assert.svh */
// ----------------------------------------------------------------------------
// Rounded-rect span unit assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_SCANLINE_SPAN_UNIT_ASSERT_SVH
`define ROUNDED_RECT_SCANLINE_SPAN_UNIT_ASSERT_SVH

// same-cycle implication
`define RRS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rrs_pkg.sv */
// ----------------------------------------------------------------------------
// Rounded-rect span package
// Register codes, corner slots and fixed-point constants.
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int POS_FRAC  = 8;
    localparam int HALF_PIX  = 1 << (POS_FRAC - 1);
    localparam int T_FRAC    = 16;
    localparam int RAD_RAW_W = 16;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 5;

    localparam int N_CORNERS = 4;
    localparam int CORNER_TL = 0;
    localparam int CORNER_TR = 1;
    localparam int CORNER_BR = 2;
    localparam int CORNER_BL = 3;

    typedef enum logic [2:0] {
        REG_RECT_LEFT,
        REG_RECT_TOP,
        REG_RECT_WIDTH,
        REG_RECT_HEIGHT,
        REG_TL_RADII,
        REG_TR_RADII,
        REG_BR_RADII,
        REG_BL_RADII
    } t_reg_idx;

endpackage

/* hw/rtl/rrs_if.sv */
// ----------------------------------------------------------------------------
// Rounded-rect span channels
// Row request channel and span result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrs_row_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] scan_row;

    modport source (output valid, output scan_row, input ready);
    modport sink   (input valid, input scan_row, output ready);
endinterface

interface rrs_span_if #(parameter int COORD_BITS = 16);
    logic                       valid;
    logic                       ready;
    logic                       span_valid;
    logic signed [COORD_BITS:0] span_start;
    logic signed [COORD_BITS:0] span_end;

    modport source (output valid, output span_valid, output span_start, output span_end,
                    input ready);
    modport sink   (input valid, input span_valid, input span_start, input span_end,
                    output ready);
endinterface

/* hw/rtl/rrs_ellipse_dx.sv */
// ----------------------------------------------------------------------------
// Ellipse inset pipeline
// dx = isqrt(rx^2 * floor(2^16 * (1 - ady^2/ry^2)) >> 16), one step per stage.
// ----------------------------------------------------------------------------
module rrs_ellipse_dx #(
    parameter int RW    = 20,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [TAG_W-1:0] i_tag,
    input  logic [RW-1:0]    i_rx,
    input  logic [RW-1:0]    i_ry,
    input  logic [RW-1:0]    i_ady,
    output logic             o_vld,
    output logic [TAG_W-1:0] o_tag,
    output logic [RW-1:0]    o_dx
);

    localparam int TF  = rrs_pkg::T_FRAC;
    localparam int QW  = TF + 1;
    localparam int SW  = 2 * RW;
    localparam int P1W = RW + QW;
    localparam int LOW = P1W / 2;
    localparam int HIW = P1W - LOW;
    localparam int LAT = TF + RW + 5;

    // squares
    logic [SW-1:0] r_a_den, r_a_asq;
    logic [RW-1:0] r_a_rx;
    logic          r_a_zero;

    // long division, index 0 holds the numerator
    logic [SW-1:0] r_d_rem  [0:TF];
    logic [SW-1:0] r_d_den  [0:TF];
    logic [TF-1:0] r_d_q    [0:TF];
    logic [RW-1:0] r_d_rx   [0:TF];
    logic          r_d_zero [0:TF];

    // rx * rx * t split into two narrow products
    logic [P1W-1:0]    r_c_p1;
    logic [RW-1:0]     r_c_rx;
    logic [LOW+RW-1:0] r_m_lo;
    logic [HIW+RW-1:0] r_m_hi;
    logic [QW-1:0]     w_t16;
    logic [P1W+RW-1:0] w_sum;

    // square root, index 0 holds the radicand
    logic [RW+1:0] r_s_rem  [0:RW];
    logic [RW-1:0] r_s_root [0:RW];
    logic [SW-1:0] r_s_n    [0:RW];

    logic             r_v [1:LAT];
    logic [TAG_W-1:0] r_t [1:LAT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_den  <= SW'(i_ry) * SW'(i_ry);
            r_a_asq  <= SW'(i_ady) * SW'(i_ady);
            r_a_rx   <= i_rx;
            r_a_zero <= (i_ady == '0);

            r_d_rem[0]  <= r_a_den - r_a_asq;
            r_d_den[0]  <= r_a_den;
            r_d_q[0]    <= '0;
            r_d_rx[0]   <= r_a_rx;
            r_d_zero[0] <= r_a_zero;
        end
    end

    for (genvar k = 1; k <= TF; k++) begin : g_div
        logic [SW:0] w_sh;
        logic        w_ge;
        assign w_sh = {r_d_rem[k-1], 1'b0};
        assign w_ge = (w_sh >= {1'b0, r_d_den[k-1]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d_rem[k]  <= w_ge ? SW'(w_sh - {1'b0, r_d_den[k-1]}) : SW'(w_sh);
                r_d_den[k]  <= r_d_den[k-1];
                r_d_q[k]    <= {r_d_q[k-1][TF-2:0], w_ge};
                r_d_rx[k]   <= r_d_rx[k-1];
                r_d_zero[k] <= r_d_zero[k-1];
            end
        end
    end

    // dy of zero gives t of exactly one
    assign w_t16 = r_d_zero[TF] ? QW'(1 << TF) : {1'b0, r_d_q[TF]};
    assign w_sum = ({r_m_hi, {LOW{1'b0}}}) + (P1W + RW)'(r_m_lo);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_p1 <= P1W'(r_d_rx[TF]) * P1W'(w_t16);
            r_c_rx <= r_d_rx[TF];

            r_m_lo <= (LOW + RW)'(r_c_p1[LOW-1:0]) * (LOW + RW)'(r_c_rx);
            r_m_hi <= (HIW + RW)'(r_c_p1[P1W-1:LOW]) * (HIW + RW)'(r_c_rx);

            r_s_rem[0]  <= '0;
            r_s_root[0] <= '0;
            r_s_n[0]    <= SW'(w_sum >> TF);
        end
    end

    for (genvar j = 1; j <= RW; j++) begin : g_sqrt
        logic [RW+1:0] w_rsh, w_trial;
        logic          w_ge;
        assign w_rsh   = {r_s_rem[j-1][RW-1:0], r_s_n[j-1][SW-1:SW-2]};
        assign w_trial = {r_s_root[j-1], 2'b01};
        assign w_ge    = (w_rsh >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s_rem[j]  <= w_ge ? (w_rsh - w_trial) : w_rsh;
                r_s_root[j] <= {r_s_root[j-1][RW-2:0], w_ge};
                r_s_n[j]    <= {r_s_n[j-1][SW-3:0], 2'b00};
            end
        end
    end

    // valid and tag ride alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= LAT; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[1] <= i_vld;
            for (int i = 2; i <= LAT; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[1] <= i_tag;
            for (int i = 2; i <= LAT; i++) begin
                r_t[i] <= r_t[i-1];
            end
        end
    end

    assign o_vld = r_v[LAT];
    assign o_tag = r_t[LAT];
    assign o_dx  = r_s_root[RW];

endmodule

/* hw/rtl/rounded_rect_scanline_span_unit.sv */
// Row transfer to span valid passes stages 1-3, the inset units (16-step t division and
//   RW-step square root, RW = 24 - RADIUS_FRAC_BITS), e1, e2 and the output register.
// Throughput: one row per cycle; a stalled output freezes the whole pipeline.
// Reset (i_rst_n low, synchronous): configuration registers zero, pipeline valid bits cleared.
// ----------------------------------------------------------------------------
// Rounded-rect scanline span unit
// Per row, the pixel run covered by a rounded rectangle, fully pipelined.
// ----------------------------------------------------------------------------
module rounded_rect_scanline_span_unit #(
    parameter int COORD_BITS       = 16,
    parameter int RADIUS_FRAC_BITS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrs_pkg::APB_AW-1:0]    paddr,
    input  logic [rrs_pkg::APB_DW-1:0]    pwdata,
    output logic [rrs_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    rrs_row_if.sink                       i_row,
    rrs_span_if.source                    o_span
);

`include "rounded_rect_scanline_span_unit_assert.svh"

    localparam int CB  = COORD_BITS;
    localparam int PF  = rrs_pkg::POS_FRAC;
    localparam int RSH = PF - RADIUS_FRAC_BITS;
    localparam int RW  = rrs_pkg::RAD_RAW_W + RSH;
    localparam int PW  = ((CB + PF + 1 > RW) ? CB + PF + 1 : RW) + 3;
    localparam int DW  = rrs_pkg::APB_DW;
    localparam int NC  = rrs_pkg::N_CORNERS;

    typedef struct packed {
        logic                 outside;
        logic                 band;
        logic signed [PW-1:0] base;
    } t_ltag;

    typedef struct packed {
        logic                 band;
        logic signed [PW-1:0] base;
    } t_rtag;

    // ---------------- configuration ----------------
    logic signed [CB-1:0] r_left, r_top;
    logic [CB-2:0]        r_width, r_height;
    logic [DW-1:0]        r_rad [NC];

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= '0;
            r_height <= '0;
            for (int c = 0; c < NC; c++) begin
                r_rad[c] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            unique case (rrs_pkg::t_reg_idx'(paddr[4:2]))
                rrs_pkg::REG_RECT_LEFT:   r_left   <= pwdata[CB-1:0];
                rrs_pkg::REG_RECT_TOP:    r_top    <= pwdata[CB-1:0];
                rrs_pkg::REG_RECT_WIDTH:  r_width  <= pwdata[CB-2:0];
                rrs_pkg::REG_RECT_HEIGHT: r_height <= pwdata[CB-2:0];
                rrs_pkg::REG_TL_RADII:    r_rad[rrs_pkg::CORNER_TL] <= pwdata;
                rrs_pkg::REG_TR_RADII:    r_rad[rrs_pkg::CORNER_TR] <= pwdata;
                rrs_pkg::REG_BR_RADII:    r_rad[rrs_pkg::CORNER_BR] <= pwdata;
                rrs_pkg::REG_BL_RADII:    r_rad[rrs_pkg::CORNER_BL] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (rrs_pkg::t_reg_idx'(paddr[4:2]))
            rrs_pkg::REG_RECT_LEFT:   prdata = {{(DW - CB){1'b0}}, r_left};
            rrs_pkg::REG_RECT_TOP:    prdata = {{(DW - CB){1'b0}}, r_top};
            rrs_pkg::REG_RECT_WIDTH:  prdata = {{(DW - CB + 1){1'b0}}, r_width};
            rrs_pkg::REG_RECT_HEIGHT: prdata = {{(DW - CB + 1){1'b0}}, r_height};
            rrs_pkg::REG_TL_RADII:    prdata = r_rad[rrs_pkg::CORNER_TL];
            rrs_pkg::REG_TR_RADII:    prdata = r_rad[rrs_pkg::CORNER_TR];
            rrs_pkg::REG_BR_RADII:    prdata = r_rad[rrs_pkg::CORNER_BR];
            rrs_pkg::REG_BL_RADII:    prdata = r_rad[rrs_pkg::CORNER_BL];
        endcase
    end

    // ---------------- geometry derived from configuration ----------------
    logic signed [PW-1:0] r_left8, r_right8, r_top8, r_bot8;
    logic signed [PW-1:0] r_edge [NC];
    logic [RW-1:0]        r_crx  [NC];
    logic [RW-1:0]        r_cry  [NC];
    logic                 r_cen  [NC];
    logic signed [PW-1:0] n_right8, n_bot8;

    assign n_right8 = (PW'(r_left) + $signed(PW'(r_width))) <<< PF;
    assign n_bot8   = (PW'(r_top) + $signed(PW'(r_height))) <<< PF;

    always_ff @(posedge i_clk) begin
        r_left8  <= PW'(r_left) <<< PF;
        r_top8   <= PW'(r_top) <<< PF;
        r_right8 <= n_right8;
        r_bot8   <= n_bot8;
        for (int c = 0; c < NC; c++) begin
            r_crx[c] <= {r_rad[c][15:0], {RSH{1'b0}}};
            r_cry[c] <= {r_rad[c][31:16], {RSH{1'b0}}};
            r_cen[c] <= (r_rad[c][15:0] != '0) && (r_rad[c][31:16] != '0);
        end
        // top corners measure down from the top edge, bottom corners up from the bottom
        r_edge[rrs_pkg::CORNER_TL] <= (PW'(r_top) <<< PF)
                                    + $signed(PW'({r_rad[rrs_pkg::CORNER_TL][31:16],
                                                   {RSH{1'b0}}}));
        r_edge[rrs_pkg::CORNER_TR] <= (PW'(r_top) <<< PF)
                                    + $signed(PW'({r_rad[rrs_pkg::CORNER_TR][31:16],
                                                   {RSH{1'b0}}}));
        r_edge[rrs_pkg::CORNER_BR] <= n_bot8
                                    - $signed(PW'({r_rad[rrs_pkg::CORNER_BR][31:16],
                                                   {RSH{1'b0}}}));
        r_edge[rrs_pkg::CORNER_BL] <= n_bot8
                                    - $signed(PW'({r_rad[rrs_pkg::CORNER_BL][31:16],
                                                   {RSH{1'b0}}}));
    end

    // ---------------- pipeline control ----------------
    logic r_out_vld;
    logic w_en;

    assign w_en        = !r_out_vld || o_span.ready;
    assign i_row.ready = w_en;

    // ---------------- stage 1: row in ----------------
    logic                 r_s1_vld;
    logic signed [CB-1:0] r_s1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_row.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_row <= i_row.scan_row;
        end
    end

    // ---------------- stage 2: band select and dy ----------------
    logic signed [PW-1:0] w_py8;
    logic                 w_tl_b, w_bl_b, w_tr_b, w_br_b;

    assign w_py8  = (PW'(r_s1_row) <<< PF) + PW'(rrs_pkg::HALF_PIX);
    assign w_tl_b = r_cen[rrs_pkg::CORNER_TL] && (w_py8 < r_edge[rrs_pkg::CORNER_TL]);
    assign w_bl_b = r_cen[rrs_pkg::CORNER_BL] && (w_py8 >= r_edge[rrs_pkg::CORNER_BL]);
    assign w_tr_b = r_cen[rrs_pkg::CORNER_TR] && (w_py8 < r_edge[rrs_pkg::CORNER_TR]);
    assign w_br_b = r_cen[rrs_pkg::CORNER_BR] && (w_py8 >= r_edge[rrs_pkg::CORNER_BR]);

    logic                 r_s2_vld, r_s2_out, r_s2_band_l, r_s2_band_r;
    logic signed [PW-1:0] r_s2_dy_l, r_s2_dy_r;
    logic [RW-1:0]        r_s2_rx_l, r_s2_ry_l, r_s2_rx_r, r_s2_ry_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // top corner wins when both bands cover the row
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_out    <= (w_py8 < r_top8) || (w_py8 >= r_bot8);
            r_s2_band_l <= w_tl_b || w_bl_b;
            r_s2_band_r <= w_tr_b || w_br_b;
            r_s2_dy_l   <= w_py8 - (w_tl_b ? r_edge[rrs_pkg::CORNER_TL]
                                           : r_edge[rrs_pkg::CORNER_BL]);
            r_s2_dy_r   <= w_py8 - (w_tr_b ? r_edge[rrs_pkg::CORNER_TR]
                                           : r_edge[rrs_pkg::CORNER_BR]);
            r_s2_rx_l   <= w_tl_b ? r_crx[rrs_pkg::CORNER_TL] : r_crx[rrs_pkg::CORNER_BL];
            r_s2_ry_l   <= w_tl_b ? r_cry[rrs_pkg::CORNER_TL] : r_cry[rrs_pkg::CORNER_BL];
            r_s2_rx_r   <= w_tr_b ? r_crx[rrs_pkg::CORNER_TR] : r_crx[rrs_pkg::CORNER_BR];
            r_s2_ry_r   <= w_tr_b ? r_cry[rrs_pkg::CORNER_TR] : r_cry[rrs_pkg::CORNER_BR];
        end
    end

    // ---------------- stage 3: |dy| and inset base ----------------
    logic          r_s3_vld;
    t_ltag         r_s3_ltag;
    t_rtag         r_s3_rtag;
    logic [RW-1:0] r_s3_ady_l, r_s3_ady_r, r_s3_rx_l, r_s3_ry_l, r_s3_rx_r, r_s3_ry_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // in band |dy| < ry, so RW bits hold it
            r_s3_ady_l        <= RW'((r_s2_dy_l < 0) ? -r_s2_dy_l : r_s2_dy_l);
            r_s3_ady_r        <= RW'((r_s2_dy_r < 0) ? -r_s2_dy_r : r_s2_dy_r);
            r_s3_rx_l         <= r_s2_rx_l;
            r_s3_ry_l         <= r_s2_ry_l;
            r_s3_rx_r         <= r_s2_rx_r;
            r_s3_ry_r         <= r_s2_ry_r;
            r_s3_ltag.outside <= r_s2_out;
            r_s3_ltag.band    <= r_s2_band_l;
            r_s3_ltag.base    <= r_left8 + $signed(PW'(r_s2_rx_l));
            r_s3_rtag.band    <= r_s2_band_r;
            r_s3_rtag.base    <= r_right8 - $signed(PW'(r_s2_rx_r));
        end
    end

    // ---------------- ellipse inset, one unit per side ----------------
    logic          w_l_vld, w_r_vld;
    t_ltag         w_ltag;
    t_rtag         w_rtag;
    logic [RW-1:0] w_dx_l, w_dx_r;

    rrs_ellipse_dx #(.RW(RW), .TAG_W($bits(t_ltag))) u_dx_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s3_vld),
        .i_tag   (r_s3_ltag),
        .i_rx    (r_s3_rx_l),
        .i_ry    (r_s3_ry_l),
        .i_ady   (r_s3_ady_l),
        .o_vld   (w_l_vld),
        .o_tag   (w_ltag),
        .o_dx    (w_dx_l)
    );

    rrs_ellipse_dx #(.RW(RW), .TAG_W($bits(t_rtag))) u_dx_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s3_vld),
        .i_tag   (r_s3_rtag),
        .i_rx    (r_s3_rx_r),
        .i_ry    (r_s3_ry_r),
        .i_ady   (r_s3_ady_r),
        .o_vld   (w_r_vld),
        .o_tag   (w_rtag),
        .o_dx    (w_dx_r)
    );

    // ---------------- e1: raw bounds ----------------
    logic                 r_e1_vld, r_e1_out;
    logic signed [PW-1:0] r_e1_lb, r_e1_rb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
        end else if (w_en) begin
            r_e1_vld <= w_l_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_out <= w_ltag.outside;
            r_e1_lb  <= w_ltag.band ? (w_ltag.base - $signed(PW'(w_dx_l))) : r_left8;
            r_e1_rb  <= w_rtag.band ? (w_rtag.base + $signed(PW'(w_dx_r))) : r_right8;
        end
    end

    // ---------------- e2: clamp and round to pixel centers ----------------
    logic                 r_e2_vld, r_e2_out;
    logic signed [PW-1:0] r_e2_start, r_e2_end;
    logic signed [PW-1:0] w_lb, w_rb;

    assign w_lb = (r_e1_lb < r_left8) ? r_left8 : r_e1_lb;
    assign w_rb = (r_e1_rb > r_right8) ? r_right8 : r_e1_rb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_vld <= 1'b0;
        end else if (w_en) begin
            r_e2_vld <= r_e1_vld;
        end
    end

    // start = ceil((lb - half) / 256), end = floor((rb - half) / 256)
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e2_out   <= r_e1_out;
            r_e2_start <= (w_lb + PW'(rrs_pkg::HALF_PIX - 1)) >>> PF;
            r_e2_end   <= (w_rb - PW'(rrs_pkg::HALF_PIX)) >>> PF;
        end
    end

    // ---------------- output register ----------------
    logic                 r_out_sv;
    logic signed [CB:0]   r_out_start, r_out_end;
    logic                 w_hit;

    assign w_hit = !r_e2_out && (r_e2_end >= r_e2_start);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_e2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_sv    <= w_hit;
            r_out_start <= w_hit ? r_e2_start[CB:0] : '0;
            r_out_end   <= w_hit ? r_e2_end[CB:0] : '0;
        end
    end

    assign o_span.valid      = r_out_vld;
    assign o_span.span_valid = r_out_sv;
    assign o_span.span_start = r_out_start;
    assign o_span.span_end   = r_out_end;

    // ---------------- assertions ----------------
    `RRS_ASSERT_IMPL(a_lane_sync, 1'b1, w_l_vld == w_r_vld, "left/right inset lanes out of step")
    `RRS_ASSERT_IMPL(a_empty_zero, r_out_vld && !r_out_sv, (r_out_start == '0) && (r_out_end == '0), "empty span with nonzero bounds")
    `RRS_ASSERT_IMPL(a_span_order, r_out_vld && r_out_sv, r_out_start <= r_out_end, "valid span with start past end")
    `RRS_ASSERT_NEXT(a_stall_freeze, r_out_vld && !o_span.ready && r_e2_vld, r_e2_vld, "stage ahead of output lost on stall")

endmodule
